>>> sv/bxgcd_pkg.sv
// ----------------------------------------------------------------------------
// bxgcd_pkg
// Shared widths, status codes, command and status types of the gcd / modular
// inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package bxgcd_pkg;

  localparam int WIDTH = 64;             // operand width, 8..64
  localparam int CW    = WIDTH + 3;      // signed Bezout coefficient width
  localparam int GW    = $clog2(WIDTH);  // common power-of-two count

  typedef logic [1:0] inv_status_t;
  localparam inv_status_t ST_OK      = 2'd0;
  localparam inv_status_t ST_NOINV   = 2'd1;
  localparam inv_status_t ST_BAD_MOD = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STRIP,
    CMD_INIT,
    CMD_STEP,
    CMD_REDUCE,
    CMD_NEG,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic any_zero;   // one operand magnitude is zero
    logic both_even;  // both operands even and nonzero
    logic u_zero;
    logic v_zero;
    logic u_even;
    logic v_even;
    logic inv_cand;   // gcd is one, no common two, modulus valid
    logic c_ok;       // coefficient lies in [0, modulus)
    logic need_neg;   // negative first operand, nonzero inverse
  } dp_sts_t;

endpackage

`default_nettype wire

>>> sv/bxgcd_if.sv
// ----------------------------------------------------------------------------
// bxgcd_if
// Valid/ready channels: operand pair in, gcd/inverse result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bxgcd_in_if;
  import bxgcd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] value_a;
  logic signed [WIDTH-1:0] value_b;

  modport source (output valid, output value_a, output value_b, input ready);
  modport sink   (input valid, input value_a, input value_b, output ready);
endinterface

interface bxgcd_out_if;
  import bxgcd_pkg::*;

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] gcd_value;
  logic [WIDTH-2:0] inverse_value;
  logic [1:0]       inverse_status;

  modport source (output valid, output gcd_value, output inverse_value,
                  output inverse_status, input ready);
  modport sink   (input valid, input gcd_value, input inverse_value,
                  input inverse_status, output ready);
endinterface

`default_nettype wire

>>> sv/binary_extended_gcd_invmod.sv
// ----------------------------------------------------------------------------
// binary_extended_gcd_invmod
// Greatest common divisor of two signed operands and the modular inverse of
// the first modulo the second, by binary extended Euclid.
//
//   channel  dir  beat payload
//   in_ch    in   value_a, value_b (signed, WIDTH bits)
//   out_ch   out  gcd_value, inverse_value, inverse_status
//
// One item at a time. Per item the sequencer loads the operands, strips
// shared twos, initialises the Euclid registers and runs the Euclid loop,
// one shift or subtract per cycle; for an inverse candidate it then adds or
// subtracts the modulus until the coefficient is reduced and negates a
// nonzero one for a negative first operand, then hands off the result. A
// zero operand goes straight from load to hand-off.
// Reset is synchronous, active low; it clears the sequencer and out valid.
// The next item is taken while a finished result waits; a stalled output
// holds the sequencer only at the hand-off of the following result.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_extended_gcd_invmod (
  input  logic        clk,
  input  logic        rst_n,
  bxgcd_in_if.sink    in_ch,
  bxgcd_out_if.source out_ch
);
  import bxgcd_pkg::*;

  cmd_t    cmd;
  dp_sts_t sts;

  bxgcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bxgcd_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .value_a        (in_ch.value_a),
    .value_b        (in_ch.value_b),
    .sts            (sts),
    .gcd_value      (out_ch.gcd_value),
    .inverse_value  (out_ch.inverse_value),
    .inverse_status (out_ch.inverse_status)
  );

endmodule

`default_nettype wire

>>> sv/bxgcd_dp.sv
// ----------------------------------------------------------------------------
// bxgcd_dp
// Datapath: operand magnitudes, binary extended Euclid registers (u, v and
// four Bezout coefficients), inverse fix-up and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bxgcd_dp (
  input  logic                              clk,
  input  bxgcd_pkg::cmd_t                   cmd,
  input  logic signed [bxgcd_pkg::WIDTH-1:0] value_a,
  input  logic signed [bxgcd_pkg::WIDTH-1:0] value_b,
  output bxgcd_pkg::dp_sts_t                sts,
  output logic [bxgcd_pkg::WIDTH-1:0]       gcd_value,
  output logic [bxgcd_pkg::WIDTH-2:0]       inverse_value,
  output logic [1:0]                        inverse_status
);
  import bxgcd_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0] p;
    logic signed [CW-1:0] q;
  } coef_pair_t;

  // halve a coefficient pair alongside its even residue
  function automatic coef_pair_t halve_pair(input logic signed [CW-1:0] p,
                                            input logic signed [CW-1:0] q,
                                            input logic signed [CW-1:0] xs,
                                            input logic signed [CW-1:0] ys);
    coef_pair_t r;
    if (!p[0] && !q[0]) begin
      r.p = p >>> 1;
      r.q = q >>> 1;
    end else begin
      r.p = (p + ys) >>> 1;
      r.q = (q - xs) >>> 1;
    end
    return r;
  endfunction

  logic [WIDTH-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic [GW-1:0]        g_r, g_nxt;
  logic                 a_neg_r, a_neg_nxt, bad_mod_r, bad_mod_nxt;
  logic [WIDTH-1:0]     u_r, u_nxt, v_r, v_nxt;
  logic signed [CW-1:0] ca_r, ca_nxt, cb_r, cb_nxt, cc_r, cc_nxt, cd_r, cd_nxt;
  logic [WIDTH-1:0]     gcd_r, gcd_nxt;
  logic [WIDTH-2:0]     inv_r, inv_nxt;
  inv_status_t          st_r, st_nxt;

  logic [WIDTH-1:0]     mag_a, mag_b;
  logic signed [CW-1:0] xs, ys;
  coef_pair_t           half_ab, half_cd;
  logic                 any_zero, inv_cand;

  assign mag_a    = value_a[WIDTH-1] ? (~value_a + 1'b1) : value_a;
  assign mag_b    = value_b[WIDTH-1] ? (~value_b + 1'b1) : value_b;
  assign xs       = signed'({{(CW-WIDTH){1'b0}}, x_r});
  assign ys       = signed'({{(CW-WIDTH){1'b0}}, y_r});
  assign half_ab  = halve_pair(ca_r, cb_r, xs, ys);
  assign half_cd  = halve_pair(cc_r, cd_r, xs, ys);
  assign any_zero = (x_r == '0) || (y_r == '0);
  assign inv_cand = !bad_mod_r && (g_r == '0) && (v_r == WIDTH'(1));

  assign sts.any_zero  = any_zero;
  assign sts.both_even = !any_zero && !x_r[0] && !y_r[0];
  assign sts.u_zero    = (u_r == '0);
  assign sts.v_zero    = (v_r == '0);
  assign sts.u_even    = !u_r[0];
  assign sts.v_even    = !v_r[0];
  assign sts.inv_cand  = inv_cand;
  assign sts.c_ok      = !cc_r[CW-1] && (cc_r < ys);
  assign sts.need_neg  = a_neg_r && (cc_r != '0);

  always_comb begin
    x_nxt       = x_r;
    y_nxt       = y_r;
    g_nxt       = g_r;
    a_neg_nxt   = a_neg_r;
    bad_mod_nxt = bad_mod_r;
    u_nxt       = u_r;
    v_nxt       = v_r;
    ca_nxt      = ca_r;
    cb_nxt      = cb_r;
    cc_nxt      = cc_r;
    cd_nxt      = cd_r;
    gcd_nxt     = gcd_r;
    inv_nxt     = inv_r;
    st_nxt      = st_r;
    unique case (cmd)
      CMD_LOAD: begin
        x_nxt       = mag_a;
        y_nxt       = mag_b;
        g_nxt       = '0;
        a_neg_nxt   = value_a[WIDTH-1];
        bad_mod_nxt = value_b[WIDTH-1] || (value_b == '0);
      end
      CMD_STRIP: begin
        x_nxt = x_r >> 1;
        y_nxt = y_r >> 1;
        g_nxt = g_r + 1'b1;
      end
      CMD_INIT: begin
        u_nxt  = x_r;
        v_nxt  = y_r;
        ca_nxt = CW'(1);
        cb_nxt = '0;
        cc_nxt = '0;
        cd_nxt = CW'(1);
      end
      CMD_STEP: begin
        if (!u_r[0]) begin
          u_nxt  = u_r >> 1;
          ca_nxt = half_ab.p;
          cb_nxt = half_ab.q;
        end else if (!v_r[0]) begin
          v_nxt  = v_r >> 1;
          cc_nxt = half_cd.p;
          cd_nxt = half_cd.q;
        end else if (u_r >= v_r) begin
          u_nxt  = u_r - v_r;
          ca_nxt = ca_r - cc_r;
          cb_nxt = cb_r - cd_r;
        end else begin
          v_nxt  = v_r - u_r;
          cc_nxt = cc_r - ca_r;
          cd_nxt = cd_r - cb_r;
        end
      end
      CMD_REDUCE: begin
        cc_nxt = cc_r[CW-1] ? (cc_r + ys) : (cc_r - ys);
      end
      CMD_NEG: begin
        cc_nxt = ys - cc_r;
      end
      CMD_OUT: begin
        if (any_zero) begin
          gcd_nxt = x_r | y_r;
        end else begin
          gcd_nxt = v_r << g_r;
        end
        if (bad_mod_r) begin
          st_nxt = ST_BAD_MOD;
        end else if (any_zero) begin
          st_nxt = (y_r == WIDTH'(1)) ? ST_OK : ST_NOINV;
        end else begin
          st_nxt = inv_cand ? ST_OK : ST_NOINV;
        end
        inv_nxt = (!bad_mod_r && !any_zero && inv_cand) ? cc_r[WIDTH-2:0] : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    g_r       <= g_nxt;
    a_neg_r   <= a_neg_nxt;
    bad_mod_r <= bad_mod_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    ca_r      <= ca_nxt;
    cb_r      <= cb_nxt;
    cc_r      <= cc_nxt;
    cd_r      <= cd_nxt;
    gcd_r     <= gcd_nxt;
    inv_r     <= inv_nxt;
    st_r      <= st_nxt;
  end

  assign gcd_value      = gcd_r;
  assign inverse_value  = inv_r;
  assign inverse_status = st_r;

endmodule

`default_nettype wire

>>> sv/bxgcd_ctrl.sv
// ----------------------------------------------------------------------------
// bxgcd_ctrl
// Sequencer: strip common twos, run Euclid steps, fix up the inverse and
// hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bxgcd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bxgcd_pkg::cmd_t    cmd,
  input  bxgcd_pkg::dp_sts_t sts
);
  import bxgcd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CORE,
    S_FIX,
    S_NEG,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = CMD_NONE;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.any_zero) begin
          state_nxt = S_FINISH;
        end else if (sts.both_even) begin
          cmd = CMD_STRIP;
        end else begin
          cmd       = CMD_INIT;
          state_nxt = S_CORE;
        end
      end
      S_CORE: begin
        if (sts.u_zero) begin
          state_nxt = sts.inv_cand ? S_FIX : S_FINISH;
        end else begin
          cmd = CMD_STEP;
        end
      end
      S_FIX: begin
        if (sts.c_ok) begin
          state_nxt = sts.need_neg ? S_NEG : S_FINISH;
        end else begin
          cmd = CMD_REDUCE;
        end
      end
      S_NEG: begin
        cmd       = CMD_NEG;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd           = CMD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  // u reaching zero leaves the odd part of the gcd in v, never zero
  a_core_v_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORE && sts.u_zero) |-> !sts.v_zero)
    else $error("core ended with v zero");

  // after stripping twos, u and v are never both even
  a_core_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORE) |-> !(sts.u_even && sts.v_even))
    else $error("u and v both even in core");

  // an inverse handed out is already reduced into [0, modulus)
  a_fin_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && sts.inv_cand && !sts.any_zero) |-> sts.c_ok)
    else $error("inverse not reduced");

  // the result register is only reloaded when free
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_OUT) |-> (!out_valid_r || out_ready))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

>>> sim/tb_binary_extended_gcd_invmod.sv
// ----------------------------------------------------------------------------
// tb_binary_extended_gcd_invmod
// Self-checking bench for the gcd / modular inverse block. Operand pairs are
// queued by an initial block, driven with random gaps and checked against a
// behavioral Euclid model, with random back-pressure on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_binary_extended_gcd_invmod;
  import bxgcd_pkg::*;

  localparam int N_RANDOM   = 1330;
  localparam int TAIL_CYC   = 6 * WIDTH;
  localparam int LIMIT_CYC  = 2_500_000;

  localparam logic [WIDTH-1:0] OP_MIN  = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] OP_MAX  = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-1:0] OP_ZERO = '0;
  localparam logic [WIDTH-1:0] OP_ONE  = WIDTH'(1);
  localparam logic [WIDTH-1:0] OP_NEG1 = '1;

  typedef struct {
    logic [WIDTH-1:0] value_a;
    logic [WIDTH-1:0] value_b;
  } operand_pair_t;

  typedef struct {
    logic [WIDTH-1:0] value_a;
    logic [WIDTH-1:0] value_b;
    logic [WIDTH-1:0] gcd_value;
    logic [WIDTH-2:0] inverse_value;
    inv_status_t      inverse_status;
  } gcd_inv_result_t;

  logic clk;
  logic rst_n;

  bxgcd_in_if  in_ch ();
  bxgcd_out_if out_ch ();

  binary_extended_gcd_invmod u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  operand_pair_t   operand_q[$];
  gcd_inv_result_t expected_q[$];
  operand_pair_t   next_pair;
  gcd_inv_result_t want;

  int   n_total;
  int   n_accepted;
  int   n_fail;
  int   in_gap;
  int   out_stall;
  logic in_beat;
  logic out_beat;
  logic calm;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [WIDTH-1:0] rand_op();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[WIDTH-1:0];
  endfunction

  // gcd of magnitudes plus inverse of value_a mod value_b via extended Euclid
  function automatic gcd_inv_result_t predict_gcd_inverse(input logic [WIDTH-1:0] a_raw,
                                                          input logic [WIDTH-1:0] b_raw);
    gcd_inv_result_t  r;
    logic             a_neg, b_neg, hi_neg, lo_neg;
    logic [WIDTH-1:0] mag_tmp;
    logic [63:0]      mag_a, mag_b, x, y, t;
    logic [63:0]      rem_hi, rem_lo, rem_nx, coef_hi, coef_lo, coef_nx, quo, inv;
    a_neg   = a_raw[WIDTH-1];
    b_neg   = b_raw[WIDTH-1];
    mag_a   = '0;
    mag_b   = '0;
    mag_tmp = a_neg ? -a_raw : a_raw;
    mag_a[WIDTH-1:0] = mag_tmp;
    mag_tmp = b_neg ? -b_raw : b_raw;
    mag_b[WIDTH-1:0] = mag_tmp;

    x = mag_a;
    y = mag_b;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end

    r.value_a   = a_raw;
    r.value_b   = b_raw;
    r.gcd_value = x[WIDTH-1:0];
    inv         = '0;

    if (b_neg || mag_b == 0) begin
      r.inverse_status = ST_BAD_MOD;
    end else begin
      rem_hi  = mag_b;
      rem_lo  = mag_a % mag_b;
      coef_hi = 0;
      coef_lo = 1;
      hi_neg  = 1'b0;
      lo_neg  = 1'b0;
      while (rem_lo != 0) begin
        quo     = rem_hi / rem_lo;
        rem_nx  = rem_hi - quo * rem_lo;
        coef_nx = coef_hi + quo * coef_lo;
        rem_hi  = rem_lo;
        rem_lo  = rem_nx;
        coef_hi = coef_lo;
        coef_lo = coef_nx;
        hi_neg  = lo_neg;
        lo_neg  = !lo_neg;
      end
      if (rem_hi != 1) begin
        r.inverse_status = ST_NOINV;
      end else begin
        r.inverse_status = ST_OK;
        if (mag_b != 1 && (mag_a % mag_b) != 0) begin
          inv = coef_hi % mag_b;
          if (hi_neg && inv != 0) inv = mag_b - inv;
          if (a_neg && inv != 0) inv = mag_b - inv;
        end
      end
    end
    r.inverse_value = inv[WIDTH-2:0];
    return r;
  endfunction

  task automatic add_pair(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b);
    operand_pair_t p;
    p.value_a = a;
    p.value_b = b;
    operand_q.push_back(p);
    n_total++;
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat) begin
      if (in_beat) in_gap = draw_wait();
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (operand_q.size() != 0) begin
        next_pair = operand_q.pop_front();
        in_ch.value_a <= next_pair.value_a;
        in_ch.value_b <= next_pair.value_b;
        in_ch.valid   <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result-side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_beat) out_stall = draw_wait();
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // beat capture, prediction and checking
  always @(posedge clk) begin
    in_beat  <= rst_n && in_ch.valid && in_ch.ready;
    out_beat <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected result beat: gcd %h inv %h status %0d",
                   out_ch.gcd_value, out_ch.inverse_value, out_ch.inverse_status);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.gcd_value !== want.gcd_value ||
            out_ch.inverse_value !== want.inverse_value ||
            out_ch.inverse_status !== want.inverse_status) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch a=%h b=%h: exp gcd %h inv %h st %0d, got gcd %h inv %h st %0d",
                     want.value_a, want.value_b, want.gcd_value, want.inverse_value,
                     want.inverse_status, out_ch.gcd_value, out_ch.inverse_value,
                     out_ch.inverse_status);
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_q.push_back(predict_gcd_inverse(in_ch.value_a, in_ch.value_b));
      n_accepted++;
      if (n_accepted % 64 == 0) calm <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    logic [WIDTH-1:0] a, b;
    int               k;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.value_a  = '0;
    in_ch.value_b  = '0;
    out_ch.ready   = 1'b0;
    in_beat        = 1'b0;
    out_beat       = 1'b0;
    calm           = 1'b0;
    in_gap         = 0;
    out_stall      = 0;
    n_total        = 0;
    n_accepted     = 0;
    n_fail         = 0;

    // directed corners
    add_pair(OP_ZERO, OP_ZERO);
    add_pair(OP_ZERO, WIDTH'(7));
    add_pair(WIDTH'(12), OP_ZERO);
    add_pair(OP_MIN, OP_ZERO);
    add_pair(OP_ZERO, OP_MIN);
    add_pair(OP_MIN, OP_MIN);
    add_pair(OP_MAX, OP_MAX);
    add_pair(OP_MIN, OP_MAX);
    add_pair(OP_MAX, OP_MIN);
    add_pair(WIDTH'(3), -WIDTH'(7));
    add_pair(WIDTH'(6), WIDTH'(8));
    add_pair(WIDTH'(6), WIDTH'(9));
    add_pair(WIDTH'(5), OP_ONE);
    add_pair(-WIDTH'(5), OP_ONE);
    add_pair(OP_ZERO, OP_ONE);
    add_pair(WIDTH'(3), WIDTH'(7));
    add_pair(-WIDTH'(3), WIDTH'(7));
    add_pair(OP_NEG1, OP_MAX);
    add_pair(OP_ONE, OP_MAX);
    add_pair(OP_MIN + OP_ONE, OP_MAX);
    add_pair(OP_MAX - OP_ONE, OP_MAX);
    add_pair(WIDTH'(48), WIDTH'(180));
    add_pair(OP_NEG1, OP_NEG1);
    add_pair(WIDTH'(14), WIDTH'(7));
    add_pair(OP_MIN, WIDTH'(3));

    for (int i = 0; i < N_RANDOM; i++) begin
      a = rand_op();
      b = rand_op();
      case ($urandom_range(0, 9))
        0, 1: ;
        2, 3: begin
          b[WIDTH-1] = 1'b0;
          b[0]       = 1'b1;
        end
        4: begin
          a = WIDTH'($urandom_range(0, 600)) - WIDTH'(300);
          b = WIDTH'($urandom_range(0, 600)) - WIDTH'(300);
        end
        5: begin
          k = $urandom_range(0, 20);
          a = (a >> $urandom_range(k, WIDTH - 1)) << k;
          b = ((b >> $urandom_range(k + 1, WIDTH - 1)) << k) | (OP_ONE << k);
          if ($urandom_range(0, 1)) a = -a;
        end
        6: begin
          b = (b >> $urandom_range(1, WIDTH - 1)) | OP_ONE;
          if ($urandom_range(0, 3) == 0) b = OP_ONE;
          a = b * WIDTH'($urandom_range(0, 1000));
          if ($urandom_range(0, 1)) a = -a;
        end
        7: begin
          b = (b >> $urandom_range(1, WIDTH - 2)) | OP_ONE;
          a = a >> $urandom_range(0, WIDTH - 2);
          if ($urandom_range(0, 1)) a = -a;
        end
        8: begin
          b[WIDTH-1] = 1'b1;
          if ($urandom_range(0, 3) == 0) b = OP_ZERO;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: a = OP_MIN;
            1: a = OP_MAX;
            2: b = OP_MAX;
            default: b = OP_ONE;
          endcase
        end
      endcase
      add_pair(a, b);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    do @(negedge clk); while (n_accepted != n_total || expected_q.size() != 0);
    repeat (TAIL_CYC) @(posedge clk);

    if (expected_q.size() != 0) n_fail++;
    if (n_fail == 0)
      $display("tb_binary_extended_gcd_invmod: PASS");
    else
      $display("tb_binary_extended_gcd_invmod: FAIL");
    $finish;
  end

  initial begin
    repeat (LIMIT_CYC) @(posedge clk);
    $display("tb_binary_extended_gcd_invmod: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

>>> binary_extended_gcd_invmod.f
sv/bxgcd_pkg.sv
sv/bxgcd_if.sv
sv/bxgcd_dp.sv
sv/bxgcd_ctrl.sv
sv/binary_extended_gcd_invmod.sv
sim/tb_binary_extended_gcd_invmod.sv
